### rtl/core/angle_bias_kalman_filter_top_macros.svh
// Assertion macros shared by the angle/bias filter RTL
`ifndef ANGLE_BIAS_KALMAN_FILTER_TOP_MACROS_SVH
`define ANGLE_BIAS_KALMAN_FILTER_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ABK_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ABK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/core/abkf_pkg.sv
// Package: types, constants and fixed-point helpers for the angle/bias filter
`default_nettype none
package abkf_pkg;
   localparam int FRAC_BITS = 24;
   localparam logic [1:0] REG_Q_ANGLE = 2'd0;
   localparam logic [1:0] REG_Q_BIAS  = 2'd1;
   localparam logic [1:0] REG_R_MEAS  = 2'd2;
   localparam logic [1:0] REG_DT      = 2'd3;

   // datapath micro-operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_RATE,      // rate = sat(gyro - bias)
      OP_ANG_PRED,  // angle = sat(angle + dt*rate)
      OP_T,         // t = dt*p11
      OP_P00_PRED,  // p00 = sat(p00 + dt*(t - p01 - p10 + qa))
      OP_P01_PRED,
      OP_P10_PRED,
      OP_P11_PRED,  // p11 = sat(p11 + qb*dt)
      OP_DIV0_INIT,
      OP_DIV1_INIT,
      OP_DIV_STEP,
      OP_K0_DONE,
      OP_K1_DONE,
      OP_INNOV,
      OP_ANG_CORR,
      OP_BIAS_CORR,
      OP_P00_CORR,
      OP_P01_CORR,
      OP_P10_CORR,
      OP_P11_CORR
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RATE, ST_ANG_PRED, ST_T, ST_P00, ST_P01, ST_P10, ST_P11,
      ST_D0_INIT, ST_D0_STEP, ST_K0, ST_D1_INIT, ST_D1_STEP, ST_K1,
      ST_INNOV, ST_ANG_CORR, ST_BIAS_CORR, ST_C00, ST_C01, ST_C10, ST_C11,
      ST_OUT
   } state_type;

   typedef struct packed {
      op_type op;
      logic   load;   // latch input sample
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // round-half-up scale by 2^24: arithmetic shift is floor
   function automatic logic signed [65:0] rnd24(input logic signed [65:0] p);
      logic signed [65:0] q;
      q = p + 66'sd8388608;
      return q >>> FRAC_BITS;
   endfunction
endpackage
`default_nettype wire

### rtl/core/abkf_if.sv
// Valid/ready channel interfaces for sample, result and register-write beats
`default_nettype none
interface abkf_req_if;
   logic               valid;
   logic               ready;
   logic signed [18:0] measured_angle;
   logic signed [22:0] gyro_rate;
   modport source(output valid, measured_angle, gyro_rate, input ready);
   modport sink(input valid, measured_angle, gyro_rate, output ready);
endinterface

interface abkf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] angle_estimate;
   logic signed [31:0] unbiased_rate;
   logic signed [31:0] bias_estimate;
   modport source(output valid, angle_estimate, unbiased_rate, bias_estimate, input ready);
   modport sink(input valid, angle_estimate, unbiased_rate, bias_estimate, output ready);
endinterface

interface abkf_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/abkf_datapath.sv
// Datapath: state registers, shared multiplier and restoring divider
`default_nettype none
module abkf_datapath
   import abkf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output status_type             status,
   input  wire logic signed [18:0] meas_in,
   input  wire logic signed [22:0] gyro_in,
   input  wire logic [30:0]        q_angle,
   input  wire logic [30:0]        q_bias,
   input  wire logic [30:0]        r_meas,
   input  wire logic [23:0]        dt,
   output logic signed [31:0]      angle_out,
   output logic signed [31:0]      rate_out,
   output logic signed [31:0]      bias_out
);
   logic signed [31:0] angle_ff, bias_ff, rate_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [31:0] t_ff, y_ff, k0_ff, k1_ff;
   logic signed [18:0] meas_ff;
   logic signed [22:0] gyro_ff;
   // divider: |num|<<24 over positive den, one quotient bit a cycle
   logic [63:0] rem_ff, rem_in;
   logic [55:0] quo_ff, quo_in;
   logic [32:0] den_ff;
   logic        neg_ff, dzero_ff;
   logic [5:0]  cnt_ff, cnt_in;

   logic signed [32:0] ma, mb;
   logic signed [65:0] prod, sum;
   logic signed [33:0] s_sum;
   logic signed [31:0] num_sel;
   logic [31:0]        num_abs;
   logic [63:0]        trial;
   logic signed [57:0] qs;
   logic signed [31:0] kval;

   // operand select for the shared multiplier; P00 prediction has its own
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (cmd.op)
         OP_ANG_PRED: begin ma = {9'd0, dt}; mb = 33'(rate_ff); end
         OP_T:        begin ma = {9'd0, dt}; mb = 33'(p11_ff); end
         OP_P11_PRED: begin ma = {2'd0, q_bias}; mb = {9'd0, dt}; end
         OP_ANG_CORR, OP_P00_CORR, OP_P01_CORR: begin ma = 33'(k0_ff); end
         OP_BIAS_CORR, OP_P10_CORR, OP_P11_CORR: begin ma = 33'(k1_ff); end
         default: ;
      endcase
      unique case (cmd.op)
         OP_ANG_CORR, OP_BIAS_CORR: mb = 33'(y_ff);
         OP_P00_CORR, OP_P10_CORR:  mb = 33'(p00_ff);
         OP_P01_CORR, OP_P11_CORR:  mb = 33'(p01_ff);
         default: ;
      endcase
   end
   // inner term needs a wider operand: t - p01 - p10 + qa fits 34 bits
   logic signed [35:0] inner;
   logic signed [65:0] prod_inner;
   assign inner = 36'(t_ff) - 36'(p01_ff) - 36'(p10_ff) + 36'($signed({1'b0, q_angle}));
   assign prod_inner = 66'(inner) * 66'($signed({1'b0, dt}));
   assign prod = 66'(ma) * 66'(mb);
   assign sum  = rnd24(cmd.op == OP_P00_PRED ? prod_inner : prod);

   assign s_sum   = 34'(p00_ff) + 34'($signed({1'b0, r_meas}));
   assign num_sel = (cmd.op == OP_DIV0_INIT) ? p00_ff : p10_ff;
   assign num_abs = num_sel[31] ? 32'(-33'(num_sel)) : num_sel;
   assign trial   = {rem_ff[62:0], quo_ff[55]};
   assign qs      = neg_ff ? -58'($signed({2'b0, quo_ff})) : 58'($signed({2'b0, quo_ff}));
   assign kval    = dzero_ff ? 32'sd0 : sat32(66'(qs));

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cmd.op == OP_DIV0_INIT || cmd.op == OP_DIV1_INIT) begin
         rem_in = '0;
         quo_in = {num_abs, 24'd0};
         cnt_in = 6'd56;
      end else if (cmd.op == OP_DIV_STEP && cnt_ff != 6'd0) begin
         cnt_in = cnt_ff - 6'd1;
         if (trial >= 64'(den_ff)) begin
            rem_in = trial - 64'(den_ff);
            quo_in = {quo_ff[54:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[54:0], 1'b0};
         end
      end
   end
   assign status.div_done = (cnt_ff == 6'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0; bias_ff <= '0; rate_ff <= '0;
         p00_ff <= '0; p01_ff <= '0; p10_ff <= '0; p11_ff <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         unique case (cmd.op)
            OP_RATE:      rate_ff  <= sat32(66'(gyro_ff) - 66'(bias_ff));
            OP_ANG_PRED:  angle_ff <= sat32(66'(angle_ff) + sum);
            OP_P00_PRED:  p00_ff   <= sat32(66'(p00_ff) + sum);
            OP_P01_PRED:  p01_ff   <= sat32(66'(p01_ff) - 66'(t_ff));
            OP_P10_PRED:  p10_ff   <= sat32(66'(p10_ff) - 66'(t_ff));
            OP_P11_PRED:  p11_ff   <= sat32(66'(p11_ff) + sum);
            OP_ANG_CORR:  angle_ff <= sat32(66'(angle_ff) + sum);
            OP_BIAS_CORR: bias_ff  <= sat32(66'(bias_ff) + sum);
            OP_P00_CORR:  p00_ff   <= sat32(66'(p00_ff) - sum);
            OP_P01_CORR:  p01_ff   <= sat32(66'(p01_ff) - sum);
            OP_P10_CORR:  p10_ff   <= sat32(66'(p10_ff) - sum);
            OP_P11_CORR:  p11_ff   <= sat32(66'(p11_ff) - sum);
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.load) begin
         meas_ff <= meas_in;
         gyro_ff <= gyro_in;
      end
      if (cmd.op == OP_T) t_ff <= 32'(sum);
      if (cmd.op == OP_INNOV) y_ff <= sat32(66'(meas_ff) - 66'(angle_ff));
      if (cmd.op == OP_DIV0_INIT || cmd.op == OP_DIV1_INIT) begin
         den_ff   <= s_sum[32:0];
         dzero_ff <= (s_sum <= 34'sd0);
         neg_ff   <= num_sel[31];
      end
      if (cmd.op == OP_K0_DONE) k0_ff <= kval;
      if (cmd.op == OP_K1_DONE) k1_ff <= kval;
   end

   assign angle_out = angle_ff;
   assign rate_out  = rate_ff;
   assign bias_out  = bias_ff;

`include "angle_bias_kalman_filter_top_macros.svh"
   `ABK_ASSERT_NEXT(a_div_load, clock, reset, cmd.op == OP_DIV0_INIT, cnt_ff == 6'd56, "divider count not loaded")
   `ABK_ASSERT_IMP(a_den_pos, clock, reset, cmd.op == OP_DIV_STEP && !dzero_ff, den_ff[32] == 1'b0, "divisor negative")
   `ABK_ASSERT_NEXT(a_cnt_dec, clock, reset, cmd.op == OP_DIV_STEP && cnt_ff != 6'd0, cnt_ff == $past(cnt_ff) - 6'd1, "divider count skipped")
endmodule
`default_nettype wire

### rtl/core/abkf_ctrl.sv
// Controller: sequences one filter step through the datapath
`default_nettype none
module abkf_ctrl
   import abkf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output cmd_type         cmd,
   input  wire status_type status
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      cmd.load  = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin cmd.load = 1'b1; state_in = ST_RATE; end
         end
         ST_RATE:     begin cmd.op = OP_RATE;     state_in = ST_ANG_PRED; end
         ST_ANG_PRED: begin cmd.op = OP_ANG_PRED; state_in = ST_T; end
         ST_T:        begin cmd.op = OP_T;        state_in = ST_P00; end
         ST_P00:      begin cmd.op = OP_P00_PRED; state_in = ST_P01; end
         ST_P01:      begin cmd.op = OP_P01_PRED; state_in = ST_P10; end
         ST_P10:      begin cmd.op = OP_P10_PRED; state_in = ST_P11; end
         ST_P11:      begin cmd.op = OP_P11_PRED; state_in = ST_D0_INIT; end
         ST_D0_INIT:  begin cmd.op = OP_DIV0_INIT; state_in = ST_D0_STEP; end
         ST_D0_STEP: begin
            cmd.op = OP_DIV_STEP;
            if (status.div_done) state_in = ST_K0;
         end
         ST_K0:       begin cmd.op = OP_K0_DONE;   state_in = ST_D1_INIT; end
         ST_D1_INIT:  begin cmd.op = OP_DIV1_INIT; state_in = ST_D1_STEP; end
         ST_D1_STEP: begin
            cmd.op = OP_DIV_STEP;
            if (status.div_done) state_in = ST_K1;
         end
         ST_K1:        begin cmd.op = OP_K1_DONE;   state_in = ST_INNOV; end
         ST_INNOV:     begin cmd.op = OP_INNOV;     state_in = ST_ANG_CORR; end
         ST_ANG_CORR:  begin cmd.op = OP_ANG_CORR;  state_in = ST_BIAS_CORR; end
         ST_BIAS_CORR: begin cmd.op = OP_BIAS_CORR; state_in = ST_C10; end
         // p10 and p11 first: they need p00 and p01 before those are corrected
         ST_C10:       begin cmd.op = OP_P10_CORR;  state_in = ST_C11; end
         ST_C11:       begin cmd.op = OP_P11_CORR;  state_in = ST_C00; end
         ST_C00:       begin cmd.op = OP_P00_CORR;  state_in = ST_C01; end
         ST_C01:       begin cmd.op = OP_P01_CORR;  state_in = ST_OUT; end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

`include "angle_bias_kalman_filter_top_macros.svh"
   `ABK_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == ST_RATE, "accepted beat not started")
   `ABK_ASSERT_IMP(a_one_side, clock, reset, req_ready, !rsp_valid, "ready while result pending")
   `ABK_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
endmodule
`default_nettype wire

### rtl/core/angle_bias_kalman_filter_top.sv
// Top level: angle/gyro-bias Kalman filter with register port
//
// Use: req carries one IMU sample per beat (measured_angle Q3.16, gyro_rate
// Q7.16). rsp returns one beat per sample: angle_estimate, unbiased_rate and
// bias_estimate, all signed Q16.16 with saturation.
// csr writes the noise terms (index 0..2, Q7.24) and the sample period
// (index 3, Q0.24). Write only while idle.
// One sample at a time: a new sample is taken the cycle after the result
// beat. The run time is set mostly by the two gain divisions, each 56
// steps of a one-bit restoring divider, and by the predict and correct
// states, which run one after another.
// Reset clears angle, bias, rate and covariance and loads the register
// defaults. A stalled receiver holds the result and req_ready low.
`default_nettype none
module angle_bias_kalman_filter_top
   import abkf_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   abkf_req_if.sink    req,
   abkf_rsp_if.source  rsp,
   abkf_csr_if.sink    csr
);
   logic [30:0] q_angle_ff, q_bias_ff, r_meas_ff;
   logic [23:0] dt_ff;
   cmd_type     cmd;
   status_type  status;

   // register file
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         q_angle_ff <= 31'd16777;
         q_bias_ff  <= 31'd50332;
         r_meas_ff  <= 31'd503316;
         dt_ff      <= 24'd83886;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_Q_ANGLE: q_angle_ff <= csr.data[30:0];
            REG_Q_BIAS:  q_bias_ff  <= csr.data[30:0];
            REG_R_MEAS:  r_meas_ff  <= csr.data[30:0];
            REG_DT:      dt_ff      <= csr.data[23:0];
            default: ;
         endcase
      end
   end

   abkf_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd), .status(status)
   );

   abkf_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .meas_in(req.measured_angle), .gyro_in(req.gyro_rate),
      .q_angle(q_angle_ff), .q_bias(q_bias_ff), .r_meas(r_meas_ff), .dt(dt_ff),
      .angle_out(rsp.angle_estimate), .rate_out(rsp.unbiased_rate),
      .bias_out(rsp.bias_estimate)
   );
endmodule
`default_nettype wire
